### hdl/smf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types for the sliding median filter: window geometry
// and the view one sorted cell shows to its neighbors.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int WINDOW = 5;
  localparam int MID    = WINDOW / 2;
  localparam int SMP_W  = 16;
  localparam int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(WINDOW - 1);

  typedef logic signed [SMP_W-1:0] sample_t;

  typedef struct packed {
    logic             vld;
    logic             le;
    logic [AGE_W-1:0] age;
    sample_t          val;
  } cell_view_t;

  // below the first cell: acts as minus infinity
  localparam cell_view_t VIEW_FLOOR = '{vld: 1'b0, le: 1'b1, age: '0, val: '0};
  // above the last cell: empty slot
  localparam cell_view_t VIEW_CEIL  = '{vld: 1'b0, le: 1'b0, age: '0, val: '0};

endpackage

`default_nettype wire

### hdl/sliding_median_filter_core.sv
`default_nettype none
// a result is registered and appears in the cycle after the sample beat that completes it
// throughput: one sample per cycle while the result is not stalled, set by the sorted cell chain
// the first WINDOW-1 samples after reset give no result
// reset clears the cell valid bits, the fill count and the output valid flag
// ----------------------------------------------------------------------------
// sliding_median_filter_core
// Running median over the last WINDOW samples, kept as a chain of sorted
// cells tagged with their age; the middle cell holds the median.
// ----------------------------------------------------------------------------
module sliding_median_filter_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire smf_pkg::sample_t in_sample,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output smf_pkg::sample_t      out_median
);
  import smf_pkg::*;

  cell_view_t       views [WINDOW];
  sample_t          nxt_vals [WINDOW];
  logic [WINDOW:0]  del_chain;
  logic [WINDOW-1:0] vld_vec;
  logic             accept;
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_median_r;

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign del_chain[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_view_t lo_v;
    cell_view_t hi_v;
    if (i == 0) begin : g_lo_edge
      assign lo_v = VIEW_FLOOR;
    end else begin : g_lo
      assign lo_v = views[i-1];
    end
    if (i == WINDOW - 1) begin : g_hi_edge
      assign hi_v = VIEW_CEIL;
    end else begin : g_hi
      assign hi_v = views[i+1];
    end
    smf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .sample   (in_sample),
      .lo_view  (lo_v),
      .hi_view  (hi_v),
      .del_lo   (del_chain[i]),
      .own_view (views[i]),
      .del_out  (del_chain[i+1]),
      .val_nxt  (nxt_vals[i])
    );
    assign vld_vec[i] = views[i].vld;
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    if (accept && (fill_cnt_r != CNT_FULL)) begin
      fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = (fill_cnt_r >= CNT_LAST);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_median_r <= nxt_vals[MID];
    end
  end

`ifndef NO_ASSERTIONS
  // occupied cells track the fill count, the number of samples seen up to WINDOW
  a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(fill_cnt_r))
    else $error("occupied cells differ from fill count");

  // a result only exists once the window is full
  a_result_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_cnt_r == CNT_FULL))
    else $error("result with window not full");

  // at most one entry ages out per beat
  a_single_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(del_chain ^ {del_chain[WINDOW-1:0], 1'b0}) <= 1)
    else $error("more than one oldest entry");

  // a stalled result blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("sample taken while result stalled");
`endif

endmodule

`default_nettype wire

### hdl/smf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window. Each beat drops the oldest sample from the
// chain, once the window is full, and inserts the new one, taking its next
// value from itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module smf_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire smf_pkg::sample_t    sample,
  input  wire smf_pkg::cell_view_t lo_view,
  input  wire smf_pkg::cell_view_t hi_view,
  input  wire logic                del_lo,
  output smf_pkg::cell_view_t      own_view,
  output logic                     del_out,
  output smf_pkg::sample_t         val_nxt
);
  import smf_pkg::*;

  logic             vld_r, vld_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  sample_t          val_r;
  logic             del_own;
  logic             le_own;
  cell_view_t       comp_cur;
  cell_view_t       comp_lo;

  assign del_own = vld_r && (age_r == AGE_OLDEST);
  assign le_own  = vld_r && !del_own && (val_r <= sample);
  assign del_out = del_own || del_lo;

  assign own_view = '{vld: vld_r, le: le_own, age: age_r, val: val_r};

  // neighbors after the oldest entry is squeezed out
  assign comp_cur = del_out ? hi_view : own_view;
  assign comp_lo  = del_lo ? own_view : lo_view;

  always_comb begin
    if (comp_cur.le) begin
      vld_nxt = comp_cur.vld;
      age_nxt = comp_cur.age + AGE_W'(1);
      val_nxt = comp_cur.val;
    end else if (comp_lo.le) begin
      vld_nxt = 1'b1;
      age_nxt = '0;
      val_nxt = sample;
    end else begin
      vld_nxt = comp_lo.vld;
      age_nxt = comp_lo.age + AGE_W'(1);
      val_nxt = comp_lo.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      age_r <= age_nxt;
      val_r <= val_nxt;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_sliding_median_filter_core.sv
// ----------------------------------------------------------------------------
// tb_sliding_median_filter_core
// Self-checking bench for the running median core. Samples go in over a
// valid/ready channel in random bursts; an in-bench window predictor works out
// each median, and every output beat is compared in order against it while
// the receiver stalls on its own pattern and once holds off for a long while.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smf_pkg::*;

  typedef enum int {
    SHAPE_FULL,
    SHAPE_NARROW,
    SHAPE_EXTREME,
    SHAPE_RAMP,
    SHAPE_SPIKE
  } shape_e;

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 40;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_median;

  sample_t win_samples [WINDOW] = '{default: '0};
  int      win_fill = 0;
  sample_t exp_medians [$];
  sample_t median_want;
  int      err_count = 0;

  logic        rx_throttle  = 1'b0;
  logic [15:0] rx_pattern   = 16'hFFFF;
  int          rx_phase     = 0;
  int          rx_hold_len  = 0;
  logic        rx_hold_trig = 1'b0;
  logic        rx_hold_seen = 1'b0;
  int          rx_hold_left = 0;

  sample_t ramp_val  = '0;
  sample_t ramp_step = 16'sd1;
  sample_t base_val  = '0;

  sliding_median_filter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  function automatic sample_t window_median();
    sample_t sorted [WINDOW];
    sample_t key;
    int      j;
    sorted = win_samples;
    for (int i = 1; i < WINDOW; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = key;
    end
    return sorted[WINDOW/2];
  endfunction

  function automatic void track_sample(input sample_t s);
    for (int i = 0; i < WINDOW - 1; i++) begin
      win_samples[i] = win_samples[i+1];
    end
    win_samples[WINDOW-1] = s;
    if (win_fill < WINDOW) begin
      win_fill++;
    end
    if (win_fill == WINDOW) begin
      exp_medians.push_back(window_median());
    end
  endfunction

  // accepted sample beats feed the predictor, output beats are checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_sample(in_sample);
      end
      if (out_valid && out_ready) begin
        if (exp_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, median %0d", out_median));
        end else begin
          median_want = exp_medians.pop_front();
          if (out_median !== median_want) begin
            report_mismatch($sformatf("median got %0d want %0d", out_median, median_want));
          end
        end
      end
    end
  end

  // receiver: long hold-off on request, else ready or a rolling stall pattern
  always @(posedge clk) begin
    if (rx_hold_trig != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_trig;
      rx_hold_left <= rx_hold_len;
      out_ready    <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else if (!rx_throttle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= rx_pattern[rx_phase % 16];
      if (rx_phase == 47) begin
        rx_phase <= 0;
        case ($urandom_range(3))
          0:       rx_pattern <= 16'hFFFF;
          1:       rx_pattern <= 16'($urandom()) | 16'($urandom());
          default: rx_pattern <= 16'($urandom());
        endcase
      end else begin
        rx_phase <= rx_phase + 1;
      end
    end
  end

  function automatic sample_t next_sample(input shape_e shape);
    sample_t v;
    case (shape)
      SHAPE_FULL: begin
        v = sample_t'($urandom());
      end
      SHAPE_NARROW: begin
        v = sample_t'(int'($urandom_range(8)) - 4);
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(3))
          0:       v = sample_t'(16'h8000);
          1:       v = sample_t'(16'h7FFF);
          2:       v = '0;
          default: v = '1;
        endcase
      end
      SHAPE_RAMP: begin
        if ($urandom_range(31) == 0) begin
          ramp_step = sample_t'(int'($urandom_range(2000)) - 1000);
        end
        ramp_val = ramp_val + ramp_step;
        v = ramp_val;
      end
      default: begin
        base_val = base_val + sample_t'(int'($urandom_range(64)) - 32);
        if ($urandom_range(4) == 0) begin
          v = ($urandom_range(2) == 0) ? sample_t'($urandom()) :
              ($urandom_range(1) == 0) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
        end else begin
          v = base_val + sample_t'(int'($urandom_range(6)) - 3);
        end
      end
    endcase
    return v;
  endfunction

  task automatic send_sample(input sample_t s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid  <= 1'b0;
      in_sample <= sample_t'($urandom());
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_stream(input int count, input shape_e shape, input bit bursty);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (bursty && burst == 0) begin
        idle_sender(($urandom_range(4) == 0) ? 0 : int'($urandom_range(6, 1)));
        burst = $urandom_range(24, 1);
      end
      send_sample(next_sample(shape));
      if (burst > 0) begin
        burst--;
      end
    end
  endtask

  // window fill phase, field extremes, ties, monotone runs and bit patterns
  task automatic test_fill_and_extremes();
    sample_t seq [$];
    seq = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
            -16'sd2, -16'sd1, 16'sd0, 16'sd1, 16'sd2};
    foreach (seq[i]) begin
      send_sample(seq[i]);
    end
  endtask

  task automatic test_random_shapes(input int total);
    int     left;
    int     seg;
    shape_e shape;
    left = total;
    while (left > 0) begin
      seg = $urandom_range(60, 10);
      if (seg > left) begin
        seg = left;
      end
      shape = shape_e'($urandom_range(4));
      rx_throttle <= ($urandom_range(3) != 0);
      send_stream(seg, shape, $urandom_range(4) != 0);
      left -= seg;
    end
  endtask

  // receiver holds off while the sender keeps offering, so the core backs up
  task automatic test_output_backpressure(input int count);
    rx_throttle  <= 1'b0;
    rx_hold_len  <= 200;
    rx_hold_trig <= ~rx_hold_trig;
    send_stream(count, SHAPE_FULL, 1'b0);
  endtask

  task automatic test_bursty_tail(input int count);
    rx_throttle <= 1'b1;
    send_stream(count / 2, SHAPE_SPIKE, 1'b1);
    send_stream(count - count / 2, SHAPE_FULL, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_and_extremes();
    test_random_shapes(750);
    test_output_backpressure(120);
    test_bursty_tail(256);
    in_valid    <= 1'b0;
    rx_throttle <= 1'b0;
    while (exp_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** sliding_median_filter_core: PASSED **");
    end else begin
      $display("** sliding_median_filter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** sliding_median_filter_core: FAILED **");
    $finish;
  end

endmodule

### sim.f
hdl/smf_pkg.sv
hdl/smf_cell.sv
hdl/sliding_median_filter_core.sv
tb/sv/tb_sliding_median_filter_core.sv
